[design/mcsu_pkg.sv]
// Package for the bond state context block.
// Holds request codes, result kinds and fixed-point constants.
// No dependencies.
package mcsu_pkg;

  localparam logic [1:0] ACT_START = 2'd0;
  localparam logic [1:0] ACT_TENSOR = 2'd1;
  localparam logic [1:0] ACT_EMBED = 2'd2;

  localparam logic KIND_CONTEXT = 1'b0;
  localparam logic KIND_ENTROPY = 1'b1;

  localparam logic signed [15:0] ONE_Q12 = 16'sd4096;
  localparam logic signed [15:0] SAT_MAX = 16'sd32767;
  localparam logic signed [15:0] SAT_MIN = -16'sd32768;
  localparam logic [16:0] LN2_Q16 = 17'd45426;
  localparam logic [12:0] RATIO_MAX = 13'd4096;
  localparam logic [4:0] EXP_TOP = 5'd24;

endpackage

[design/mps_context_state_update.sv]
// Bond state context block: accumulation, normalization, entropy and context values.
// Depends on mcsu_pkg. All multiplications run through one shared registered multiplier.
//
// Channel  Ports                              Handshake
// request  action, value, final_step         start high and busy low
// result   kind, value_res, position         strobe high for one cycle
//
// Start and embedding requests complete in the idle state; an embedding result is registered
// and follows on the next cycle. A tensor element passes through the multiply and add states;
// the last one of a step adds rounding of every amplitude, the ratio search on the multiplier
// and, unless final, the log walk. busy is high throughout. rst is synchronous and restores
// the one-hot state. The receiver cannot stall results.
module mps_context_state_update #(
  parameter int BOND_SIZE = 8,
  parameter int PHYS_SIZE = 2,
  parameter int EMB_DIM = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         action,
  input  logic signed [15:0] value,
  input  logic               final_step,
  output logic               strobe,
  output logic               kind,
  output logic signed [15:0] value_res,
  output logic [3:0]         position
);
  import mcsu_pkg::*;

  localparam int BW = $clog2(BOND_SIZE);
  localparam int PW = (PHYS_SIZE > 1) ? $clog2(PHYS_SIZE) : 1;
  localparam int EW = (EMB_DIM > 1) ? $clog2(EMB_DIM) : 1;
  localparam int NW = 31 + BW;
  localparam int NH = (NW + 1) / 2;
  localparam int TW = 26 + NW + 2;
  localparam int SW = 48 + BW;

  typedef enum logic [4:0] {
    S_IDLE, S_MAC_MUL, S_MAC_ADD, S_RND, S_NSUM, S_NCHK, S_MAG, S_MAGW, S_SRCH,
    S_TSQ, S_NLO, S_NHI, S_ENT, S_EP, S_ENORM, S_ESQ, S_ESQW, S_EL, S_EACC,
    S_ELN, S_EOUT
  } state_t;

  state_t state;
  logic signed [15:0] amp [BOND_SIZE];
  logic signed [39:0] acc [BOND_SIZE];
  logic [BW-1:0] li, ri, k, aidx;
  logic [PW-1:0] pi;
  logic [EW-1:0] eidx;
  logic signed [15:0] vreg;
  logic fin;
  logic [NW-1:0] n;
  logic [TW-1:0] rhs, plo;
  logic [12:0] lo, hi, mid;
  logic [25:0] t2;
  logic [24:0] pq;
  logic [30:0] m;
  logic [4:0] ex;
  logic [15:0] frac;
  logic [3:0] it;
  logic signed [SW-1:0] esum;
  logic signed [67:0] prod;

  logic signed [33:0] ma, mb;
  logic [BW-1:0] rsel;
  logic signed [15:0] rd_amp;
  logic signed [39:0] rd_acc;
  logic signed [40:0] mac_sum;
  logic signed [39:0] mac_sat;
  logic signed [40:0] rx;
  logic signed [28:0] rq;
  logic signed [15:0] rnd_s;
  logic [13:0] mid_c;
  logic [13:0] tt;
  logic [TW-1:0] total;
  logic [31:0] mm;
  logic signed [22:0] lq;
  logic [SW-21:0] tsh;
  logic [47:0] eround;
  logic signed [16:0] csum;
  logic signed [15:0] csat;
  logic [EW+3:0] pos_ext;
  logic k_last;

  assign busy = (state != S_IDLE);
  assign k_last = (k == BW'(BOND_SIZE - 1));

  always_comb begin
    case (state)
      S_IDLE: rsel = aidx;
      S_MAC_MUL, S_MAC_ADD: rsel = li;
      default: rsel = k;
    endcase
  end

  assign rd_amp = amp[rsel];
  assign rd_acc = acc[(state == S_MAC_ADD) ? ri : k];
  assign mac_sum = 41'(rd_acc) + 41'($signed(prod[31:0]));

  always_comb begin
    if (mac_sum > 41'sh7F_FFFF_FFFF) mac_sat = 40'sh7F_FFFF_FFFF;
    else if (mac_sum < -41'sh80_0000_0000) mac_sat = -40'sh80_0000_0000;
    else mac_sat = mac_sum[39:0];
  end

  assign rx = 41'(rd_acc) + 41'sd2048;
  assign rq = rx[40:12];

  always_comb begin
    if (rq > 29'(SAT_MAX)) rnd_s = SAT_MAX;
    else if (rq < 29'(SAT_MIN)) rnd_s = SAT_MIN;
    else rnd_s = rq[15:0];
  end

  assign mid_c = (14'(lo) + 14'(hi) + 14'd1) >> 1;
  assign tt = {mid_c[12:0], 1'b0} - 14'd1;
  assign total = plo + (TW'(prod[TW-1:0]) << NH);
  assign mm = prod[61:30];
  assign lq = $signed({1'b0, 6'(EXP_TOP) - 6'(ex), 16'd0}) - $signed({7'd0, frac});
  assign tsh = (esum < 0) ? '0 : (SW-20)'(esum >>> 20);
  assign eround = prod[47:0] + 48'h80_0000;
  assign csum = 17'(value) + 17'(rd_amp);

  always_comb begin
    if (csum > 17'(SAT_MAX)) csat = SAT_MAX;
    else if (csum < 17'(SAT_MIN)) csat = SAT_MIN;
    else csat = csum[15:0];
  end

  assign pos_ext = {4'd0, eidx};

  always_comb begin
    ma = '0;
    mb = '0;
    case (state)
      S_MAC_MUL: begin
        ma = 34'(rd_amp);
        mb = 34'(vreg);
      end
      S_RND: begin
        ma = 34'(rnd_s);
        mb = 34'(rnd_s);
      end
      S_MAG, S_ENT: begin
        ma = 34'(rd_amp);
        mb = 34'(rd_amp);
      end
      S_SRCH: begin
        ma = $signed({20'd0, tt});
        mb = $signed({20'd0, tt});
      end
      S_TSQ: begin
        ma = $signed({8'd0, prod[25:0]});
        mb = $signed(34'(n[NH-1:0]));
      end
      S_NLO: begin
        ma = $signed({8'd0, t2});
        mb = $signed(34'(n >> NH));
      end
      S_ESQ: begin
        ma = $signed({3'd0, m});
        mb = $signed({3'd0, m});
      end
      S_EL: begin
        ma = $signed({9'd0, pq});
        mb = 34'(lq);
      end
      S_ELN: begin
        ma = $signed(34'(tsh));
        mb = $signed({17'd0, LN2_Q16});
      end
      default: begin
        ma = '0;
        mb = '0;
      end
    endcase
  end

  always_ff @(posedge clk) prod <= ma * mb;

  always_ff @(posedge clk) begin
    strobe <= 1'b0;
    if (rst) begin
      state <= S_IDLE;
      for (int i = 0; i < BOND_SIZE; i++) begin
        amp[i] <= '0;
        acc[i] <= '0;
      end
      amp[0] <= ONE_Q12;
      li <= '0;
      ri <= '0;
      pi <= '0;
      eidx <= '0;
      aidx <= '0;
      k <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (start) begin
            case (action)
              ACT_START: begin
                for (int i = 0; i < BOND_SIZE; i++) begin
                  amp[i] <= '0;
                  acc[i] <= '0;
                end
                amp[0] <= ONE_Q12;
                li <= '0;
                ri <= '0;
                pi <= '0;
                eidx <= '0;
                aidx <= '0;
              end
              ACT_TENSOR: begin
                vreg <= value;
                fin <= final_step;
                state <= S_MAC_MUL;
              end
              ACT_EMBED: begin
                strobe <= 1'b1;
                kind <= KIND_CONTEXT;
                value_res <= csat;
                position <= pos_ext[3:0];
                if (eidx == EW'(EMB_DIM - 1)) begin
                  eidx <= '0;
                  aidx <= '0;
                end else begin
                  eidx <= eidx + 1'b1;
                  aidx <= (aidx == BW'(BOND_SIZE - 1)) ? '0 : aidx + 1'b1;
                end
              end
              default: begin
              end
            endcase
          end
        end
        S_MAC_MUL: state <= S_MAC_ADD;
        S_MAC_ADD: begin
          acc[ri] <= mac_sat;
          state <= S_IDLE;
          if (ri != BW'(BOND_SIZE - 1)) begin
            ri <= ri + 1'b1;
          end else begin
            ri <= '0;
            if (pi != PW'(PHYS_SIZE - 1)) begin
              pi <= pi + 1'b1;
            end else begin
              pi <= '0;
              if (li != BW'(BOND_SIZE - 1)) begin
                li <= li + 1'b1;
              end else begin
                li <= '0;
                k <= '0;
                n <= '0;
                state <= S_RND;
              end
            end
          end
        end
        S_RND: begin
          amp[k] <= rnd_s;
          state <= S_NSUM;
        end
        S_NSUM: begin
          n <= n + NW'(prod[30:0]);
          if (k_last) begin
            k <= '0;
            state <= S_NCHK;
          end else begin
            k <= k + 1'b1;
            state <= S_RND;
          end
        end
        S_NCHK: begin
          for (int i = 0; i < BOND_SIZE; i++) acc[i] <= '0;
          eidx <= '0;
          aidx <= '0;
          esum <= '0;
          if (n != '0) state <= S_MAG;
          else state <= fin ? S_IDLE : S_ENT;
        end
        S_MAG: state <= S_MAGW;
        S_MAGW: begin
          rhs <= TW'(prod[30:0]) << 26;
          lo <= '0;
          hi <= RATIO_MAX;
          state <= S_SRCH;
        end
        S_SRCH: begin
          if (lo < hi) begin
            mid <= mid_c[12:0];
            state <= S_TSQ;
          end else begin
            amp[k] <= (rd_amp < 0) ? -$signed({3'd0, lo}) : $signed({3'd0, lo});
            if (k_last) begin
              k <= '0;
              state <= fin ? S_IDLE : S_ENT;
            end else begin
              k <= k + 1'b1;
              state <= S_MAG;
            end
          end
        end
        S_TSQ: begin
          t2 <= prod[25:0];
          state <= S_NLO;
        end
        S_NLO: begin
          plo <= TW'(prod[TW-1:0]);
          state <= S_NHI;
        end
        S_NHI: begin
          if (total <= rhs) lo <= mid;
          else hi <= mid - 1'b1;
          state <= S_SRCH;
        end
        S_ENT: state <= S_EP;
        S_EP: begin
          pq <= prod[24:0];
          m <= {prod[24:0], 6'd0};
          ex <= EXP_TOP;
          if (prod[24:0] == '0) begin
            if (k_last) state <= S_ELN;
            else begin
              k <= k + 1'b1;
              state <= S_ENT;
            end
          end else begin
            state <= S_ENORM;
          end
        end
        S_ENORM: begin
          if (!m[30]) begin
            m <= m << 1;
            ex <= ex - 1'b1;
          end else begin
            it <= '0;
            frac <= '0;
            state <= S_ESQ;
          end
        end
        S_ESQ: state <= S_ESQW;
        S_ESQW: begin
          frac <= {frac[14:0], mm[31]};
          m <= mm[31] ? mm[31:1] : mm[30:0];
          it <= it + 1'b1;
          state <= (it == 4'd15) ? S_EL : S_ESQ;
        end
        S_EL: state <= S_EACC;
        S_EACC: begin
          esum <= esum + SW'(prod[SW-1:0]);
          if (k_last) state <= S_ELN;
          else begin
            k <= k + 1'b1;
            state <= S_ENT;
          end
        end
        S_ELN: state <= S_EOUT;
        S_EOUT: begin
          strobe <= 1'b1;
          kind <= KIND_ENTROPY;
          value_res <= (eround[47:24] > 24'd32767) ? SAT_MAX : $signed(eround[39:24]);
          position <= '0;
          k <= '0;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

[dv/mps_context_state_update_test.sv]
// Self-checking testbench for the bond state context block. Depends on mcsu_pkg and
// mps_context_state_update. Drives a directed table and random request sequences and
// checks every result against a bit-accurate predictor or a typed row's expected value.
module mps_context_state_update_test;
  import mcsu_pkg::*;

  localparam int BOND = 8;
  localparam int PHYS = 2;
  localparam int EMB = 16;
  localparam int STEP_LEN = BOND * PHYS * BOND;
  localparam int RANDOM_ITEMS = 600;
  localparam logic [1:0] ACT_NONE = 2'd3;

  typedef struct {
    logic [1:0] act;
    logic signed [15:0] val;
    logic fin;
    bit fill;
    bit typed;
    logic k;
    logic signed [15:0] ev;
    logic [3:0] ep;
  } dir_row_t;

  typedef struct {
    logic k;
    logic signed [15:0] v;
    logic [3:0] p;
  } context_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic [1:0] action = ACT_START;
  logic signed [15:0] value = '0;
  logic final_step = 1'b0;
  logic busy, strobe, kind;
  logic signed [15:0] value_res;
  logic [3:0] position;

  mps_context_state_update i_dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .action(action),
    .value(value), .final_step(final_step), .strobe(strobe), .kind(kind),
    .value_res(value_res), .position(position)
  );

  always #2 clk = ~clk;

  longint amp[BOND];
  longint acc[BOND];
  int left_i, phys_i, right_i, embed_i;
  context_result_t expected_results[$];
  int accepted = 0;
  int mismatches = 0;
  bit typed_now = 0;
  context_result_t typed_result;
  bit idle_on = 1;

  task automatic report(input string msg);
    $display("mismatch at %0t: %s", $time, msg);
    mismatches++;
  endtask

  function automatic longint sat(input longint x, input longint lo, input longint hi);
    if (x < lo) return lo;
    if (x > hi) return hi;
    return x;
  endfunction

  function automatic longint round_q12(input longint a);
    longint x, q;
    x = a + 2048;
    if (x >= 0) q = x / 4096;
    else q = -((-x + 4095) / 4096);
    return sat(q, -32768, 32767);
  endfunction

  function automatic longint unsigned norm_ratio(input longint unsigned mag,
                                                 input longint unsigned n);
    longint unsigned rhs, lo, hi, mid, t;
    rhs = (8192 * mag) * (8192 * mag);
    lo = 0;
    hi = ONE_Q12;
    while (lo < hi) begin
      mid = (lo + hi + 1) / 2;
      t = 2 * mid - 1;
      if (t * t * n <= rhs) lo = mid;
      else hi = mid - 1;
    end
    return lo;
  endfunction

  function automatic longint neg_log2(input longint unsigned p);
    int e;
    longint unsigned m;
    longint frac;
    e = 0;
    frac = 0;
    while (e < 62 && (p >> (e + 1)) != 0) e++;
    m = p << (30 - e);
    for (int i = 0; i < 16; i++) begin
      m = (m * m) >> 30;
      frac = frac << 1;
      if (m >= (64'd1 << 31)) begin
        frac = frac | 1;
        m = m >> 1;
      end
    end
    return (24 - longint'(e)) * 65536 - frac;
  endfunction

  function automatic longint bond_entropy();
    longint s;
    longint unsigned p, t;
    s = 0;
    for (int k = 0; k < BOND; k++) begin
      p = amp[k] * amp[k];
      if (p != 0) s += longint'(p) * neg_log2(p);
    end
    if (s < 0) s = 0;
    t = longint'(s) >>> 20;
    t = (t * LN2_Q16 + (64'd1 << 23)) >> 24;
    if (t > 32767) t = 32767;
    return t;
  endfunction

  task automatic clear_state(input bit one_hot);
    for (int k = 0; k < BOND; k++) begin
      if (one_hot) amp[k] = (k == 0) ? ONE_Q12 : 0;
      acc[k] = 0;
    end
    left_i = 0;
    phys_i = 0;
    right_i = 0;
    embed_i = 0;
  endtask

  task automatic normalize_step();
    longint s[BOND];
    longint unsigned n, mag, r;
    n = 0;
    for (int k = 0; k < BOND; k++) begin
      s[k] = round_q12(acc[k]);
      n += s[k] * s[k];
    end
    for (int k = 0; k < BOND; k++) begin
      if (n == 0) begin
        amp[k] = s[k];
      end else begin
        mag = (s[k] < 0) ? -s[k] : s[k];
        r = norm_ratio(mag, n);
        amp[k] = (s[k] < 0) ? -longint'(r) : longint'(r);
      end
    end
    clear_state(0);
  endtask

  task automatic predict_request(input logic [1:0] a, input logic signed [15:0] v,
                                 input logic f);
    context_result_t r;
    if (a == ACT_START) begin
      clear_state(1);
    end else if (a == ACT_TENSOR) begin
      acc[right_i] = sat(acc[right_i] + amp[left_i] * longint'(v),
                         -(64'sd1 <<< 39), (64'sd1 <<< 39) - 1);
      right_i++;
      if (right_i == BOND) begin
        right_i = 0;
        phys_i++;
        if (phys_i == PHYS) begin
          phys_i = 0;
          left_i++;
          if (left_i == BOND) begin
            normalize_step();
            if (!f) begin
              r.k = KIND_ENTROPY;
              r.v = 16'(bond_entropy());
              r.p = '0;
              expected_results.push_back(typed_now ? typed_result : r);
            end
          end
        end
      end
    end else if (a == ACT_EMBED) begin
      r.k = KIND_CONTEXT;
      r.v = 16'(sat(longint'(v) + amp[embed_i % BOND], -32768, 32767));
      r.p = 4'(embed_i);
      embed_i = (embed_i + 1) % EMB;
      expected_results.push_back(typed_now ? typed_result : r);
    end
  endtask

  always @(posedge clk) begin
    if (!rst && start && !busy) begin
      accepted++;
      predict_request(action, value, final_step);
    end
    if (!rst && strobe) begin
      if (expected_results.size() == 0) begin
        report($sformatf("unexpected result kind %0b value %0d", kind, value_res));
      end else begin
        context_result_t e;
        e = expected_results.pop_front();
        if (kind !== e.k || value_res !== e.v || position !== e.p)
          report($sformatf("got kind %0b value %0d pos %0d, want %0b %0d %0d",
                           kind, value_res, position, e.k, e.v, e.p));
      end
    end
  end

  task automatic send(input logic [1:0] a, input logic signed [15:0] v, input logic f);
    int n;
    while (idle_on && $urandom_range(99) < 31) begin
      start <= 1'b0;
      @(negedge clk);
    end
    start <= 1'b1;
    action <= a;
    value <= v;
    final_step <= f;
    n = accepted;
    do @(negedge clk); while (accepted == n);
  endtask

  function automatic logic signed [15:0] styled_value(input int style);
    case (style)
      0: return 16'($urandom);
      1: return 16'($signed($urandom_range(128)) - 64);
      2: return ($urandom_range(9) == 0) ? 16'($urandom) : 16'sd0;
      default: return 16'($signed($urandom_range(2)) - 1);
    endcase
  endfunction

  dir_row_t dir_table[$];

  initial begin
    int sent, style, cnt;
    logic f;
    dir_table.push_back('{ACT_EMBED, 16'sd0, 0, 0, 1, KIND_CONTEXT, ONE_Q12, 4'd0});
    dir_table.push_back('{ACT_EMBED, SAT_MAX, 0, 0, 1, KIND_CONTEXT, SAT_MAX, 4'd1});
    dir_table.push_back('{ACT_EMBED, SAT_MIN, 1, 0, 1, KIND_CONTEXT, SAT_MIN, 4'd2});
    dir_table.push_back('{ACT_NONE, -16'sd1, 1, 0, 0, 0, 0, 0});
    dir_table.push_back('{ACT_EMBED, 16'sd0, 0, 0, 1, KIND_CONTEXT, 16'sd0, 4'd3});
    dir_table.push_back('{ACT_START, 16'sd0, 0, 0, 0, 0, 0, 0});
    dir_table.push_back('{ACT_TENSOR, 16'sd0, 0, 1, 1, KIND_ENTROPY, 16'sd0, 4'd0});
    dir_table.push_back('{ACT_EMBED, 16'sd100, 0, 0, 1, KIND_CONTEXT, 16'sd100, 4'd0});
    dir_table.push_back('{ACT_START, 16'sd0, 0, 0, 0, 0, 0, 0});
    dir_table.push_back('{ACT_TENSOR, ONE_Q12, 0, 0, 0, 0, 0, 0});
    dir_table.push_back('{ACT_START, 16'sd0, 0, 0, 0, 0, 0, 0});
    dir_table.push_back('{ACT_EMBED, 16'sd5, 0, 0, 1, KIND_CONTEXT, 16'sd4101, 4'd0});
    dir_table.push_back('{ACT_TENSOR, SAT_MAX, 0, 1, 0, 0, 0, 0});
    dir_table.push_back('{ACT_EMBED, SAT_MIN, 0, 0, 0, 0, 0, 0});
    dir_table.push_back('{ACT_TENSOR, SAT_MIN, 1, 1, 0, 0, 0, 0});
    dir_table.push_back('{ACT_EMBED, SAT_MAX, 0, 0, 0, 0, 0, 0});
    dir_table.push_back('{ACT_TENSOR, -16'sd1, 0, 1, 0, 0, 0, 0});
    dir_table.push_back('{ACT_EMBED, -16'sd7, 0, 0, 0, 0, 0, 0});

    clear_state(1);
    repeat (2) @(negedge clk);
    rst <= 1'b0;

    foreach (dir_table[i]) begin
      cnt = dir_table[i].fill ? STEP_LEN : 1;
      for (int j = 0; j < cnt; j++) begin
        typed_now = dir_table[i].typed && (j == cnt - 1);
        typed_result = '{dir_table[i].k, dir_table[i].ev, dir_table[i].ep};
        send(dir_table[i].act, dir_table[i].val, dir_table[i].fin);
      end
    end
    typed_now = 0;

    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      idle_on = !(sent > 300 && sent < 550);
      case ($urandom_range(99)) inside
        [0:7]: begin
          send(ACT_START, 16'($urandom), 1'($urandom));
          sent++;
        end
        [8:11]: begin
          send(ACT_NONE, 16'($urandom), 1'($urandom));
        end
        [12:21]: begin
          cnt = $urandom_range(1, STEP_LEN - 1);
          style = $urandom_range(3);
          repeat (cnt) send(ACT_TENSOR, styled_value(style), 1'($urandom));
          send(ACT_START, 16'($urandom), 1'b0);
          sent += cnt + 1;
        end
        [22:59]: begin
          style = $urandom_range(3);
          f = ($urandom_range(3) == 0);
          for (int j = 0; j < STEP_LEN - 1; j++)
            send(ACT_TENSOR, styled_value(style), 1'($urandom));
          send(ACT_TENSOR, styled_value(style), f);
          sent += STEP_LEN;
        end
        default: begin
          cnt = $urandom_range(1, 20);
          repeat (cnt) send(ACT_EMBED, 16'($urandom), 1'($urandom));
          sent += cnt;
        end
      endcase
    end
    start <= 1'b0;

    while (expected_results.size() != 0) @(negedge clk);
    repeat (2000) @(negedge clk);
    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("mps_context_state_update test passed");
    end else begin
      $display("mps_context_state_update test failed");
    end
    $finish;
  end

  initial begin
    #4000000;
    $display("mps_context_state_update test failed");
    $finish;
  end

endmodule
